// ----- rtl/core/bilinear_texture_sampler_unit_macros.svh -----
// Assertion macros for the bilinear texture sampler checker.
`ifndef BILINEAR_TEXTURE_SAMPLER_UNIT_MACROS_SVH
`define BILINEAR_TEXTURE_SAMPLER_UNIT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define BTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bts check failed");

// Next-cycle implication, off while in reset.
`define BTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bts check failed");

// Next-cycle implication, also active during reset.
`define BTS_ASSERT_NXT_ANY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bts check failed");

`endif

// ----- rtl/core/bts_pkg.sv -----
// Package: constants and types of the bilinear texture sampler.
package bts_pkg;
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DIM_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int POS_W       = 16 + DIM_W;   // scaled coordinate
  localparam int WGT_W       = 17;           // weight up to 65536
  localparam int PROD_W      = 8 + WGT_W;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd2;

  localparam logic [1:0] FMT_RGB  = 2'd1;
  localparam logic [1:0] FMT_RGBA = 2'd2;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [7:0]        byte_t;
  typedef logic [ADDR_W-1:0] addr_t;
endpackage

// ----- rtl/core/bts_if.sv -----
// Handshake channels: sample/load words in, filtered texel words out.
interface bts_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] texel_index;
  logic [7:0]  texel_red;
  logic [7:0]  texel_green;
  logic [7:0]  texel_blue;
  logic [7:0]  texel_alpha;
  logic [15:0] coord_u;
  logic [15:0] coord_v;
  modport source (output valid, op, texel_index, texel_red, texel_green, texel_blue,
                  texel_alpha, coord_u, coord_v, input ready);
  modport sink (input valid, op, texel_index, texel_red, texel_green, texel_blue,
                texel_alpha, coord_u, coord_v, output ready);
endinterface

interface bts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_alpha;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  modport source (output valid, out_alpha, out_red, out_green, out_blue, input ready);
  modport sink (input valid, out_alpha, out_red, out_green, out_blue, output ready);
endinterface

// ----- rtl/core/bts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- rtl/core/bilinear_texture_sampler_unit.sv -----
// Top level: pipelined bilinear texture sampler with texel store.
// Use: load words (op=0) write one RGBA texel at texel_index into the store;
// sample words (op=1) bring u,v as 16-bit fractions and return one filtered
// ARGB word on the out channel. Loads return nothing.
// The cfg port sets width, height and pixel format; write it only while idle.
// Path: a sample passes stages A, B, C, D and E, then the output register.
// Throughput: one word per clock unless the output stalls. The four neighbour fetches go to four
// copies of the 64K x 32 texel store, each with one read port, all written
// by every load; the rest is a six-register pipeline.
// A load followed by a sample on the next cycle already sees the new texel.
// Stall: when out is valid and not taken, the whole pipeline holds and
// in_ch.ready drops; nothing is lost or repeated. An empty output register
// keeps ready high even while the pipeline is full of work.
// Reset (rst_n low, synchronous): pipeline emptied, width and height 1,
// format unsupported. The texel store is not cleared; load before sampling.
module bilinear_texture_sampler_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  bts_in_if.sink                         in_ch,
  bts_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bts_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bts_pkg::*;

  dim_t       width_r, height_r;
  logic [1:0] format_r;
  dim_t       w_sat, h_sat;
  logic       adv;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= dim_t'(1);
      height_r <= dim_t'(1);
      format_r <= 2'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
        REG_FORMAT: format_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_sat = width_r;
    if (width_r == '0) w_sat = dim_t'(1);
    else if (32'(width_r) > MAX_WIDTH) w_sat = dim_t'(MAX_WIDTH);
    h_sat = height_r;
    if (height_r == '0) h_sat = dim_t'(1);
    else if (32'(height_r) > MAX_HEIGHT) h_sat = dim_t'(MAX_HEIGHT);
  end

  // whole pipeline moves together
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // stage A: captured word
  logic        a_vld_r, a_op_r;
  logic [15:0] a_idx_r, a_u_r, a_v_r;
  logic [31:0] a_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_op_r   <= in_ch.op;
      a_idx_r  <= in_ch.texel_index;
      a_word_r <= {in_ch.texel_alpha, in_ch.texel_blue, in_ch.texel_green, in_ch.texel_red};
      a_u_r    <= in_ch.coord_u;
      a_v_r    <= in_ch.coord_v;
    end
  end

  // stage B: scaled coordinates
  logic             b_vld_r, b_op_r;
  logic [15:0]      b_idx_r;
  logic [31:0]      b_word_r;
  logic [POS_W-1:0] b_px_r, b_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_op_r   <= a_op_r;
      b_idx_r  <= a_idx_r;
      b_word_r <= a_word_r;
      b_px_r   <= POS_W'(a_u_r * w_sat);
      b_py_r   <= POS_W'(a_v_r * h_sat);
    end
  end

  // stage C: texel columns, row bases, fractions
  dim_t                x0, y0, y1;
  logic [DIM_W:0]      x0_inc, y0_inc;
  logic                c_vld_r, c_op_r;
  logic [15:0]         c_idx_r;
  logic [31:0]         c_word_r;
  dim_t                c_x0_r, c_x1_r;
  addr_t               c_row0_r, c_row1_r;
  byte_t               c_fx_r, c_fy_r;

  assign x0     = b_px_r[POS_W-1:16];
  assign y0     = b_py_r[POS_W-1:16];
  assign x0_inc = {1'b0, x0} + 1'b1;
  assign y0_inc = {1'b0, y0} + 1'b1;
  assign y1     = (y0_inc < {1'b0, h_sat}) ? y0_inc[DIM_W-1:0] : h_sat - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_op_r   <= b_op_r;
      c_idx_r  <= b_idx_r;
      c_word_r <= b_word_r;
      c_x0_r   <= x0;
      c_x1_r   <= (x0_inc < {1'b0, w_sat}) ? x0_inc[DIM_W-1:0] : w_sat - 1'b1;
      c_row0_r <= ADDR_W'(y0 * w_sat);
      c_row1_r <= ADDR_W'(y1 * w_sat);
      c_fx_r   <= b_px_r[15:8];
      c_fy_r   <= b_py_r[15:8];
    end
  end

  // stage C -> D: store access; loads write, samples read four neighbours
  addr_t            c_addr [4];
  logic [31:0]      d_tex  [4];
  logic             st_we;
  logic [DIM_W-1:0] fx_n, fy_n;

  assign c_addr[0] = ADDR_W'(c_row0_r + c_x0_r);
  assign c_addr[1] = ADDR_W'(c_row0_r + c_x1_r);
  assign c_addr[2] = ADDR_W'(c_row1_r + c_x0_r);
  assign c_addr[3] = ADDR_W'(c_row1_r + c_x1_r);
  assign st_we     = adv && c_vld_r && (c_op_r == OP_LOAD) && (32'(c_idx_r) < STORE_DEPTH);

  for (genvar k = 0; k < 4; k++) begin : g_store
    bts_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_ram (
      .clk   (clk),
      .we    (st_we),
      .waddr (ADDR_W'(c_idx_r)),
      .wdata (c_word_r),
      .re    (adv),
      .raddr (c_addr[k]),
      .rdata (d_tex[k])
    );
  end

  logic             d_vld_r, d_smp_r;
  logic [WGT_W-1:0] d_wgt_r [4];

  assign fx_n = 9'd256 - {1'b0, c_fx_r};
  assign fy_n = 9'd256 - {1'b0, c_fy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_smp_r    <= (c_op_r == OP_SAMPLE);
      d_wgt_r[0] <= WGT_W'(fx_n * fy_n);
      d_wgt_r[1] <= WGT_W'(c_fx_r * fy_n);
      d_wgt_r[2] <= WGT_W'(fx_n * c_fy_r);
      d_wgt_r[3] <= WGT_W'(c_fx_r * c_fy_r);
    end
  end

  // stage E: per-channel, per-neighbour products
  logic              e_vld_r;
  logic [PROD_W-1:0] e_prod_r [4][4];   // [channel][neighbour]

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (adv) begin
      e_vld_r <= d_vld_r && d_smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        for (int n = 0; n < 4; n++) begin
          e_prod_r[c][n] <= PROD_W'(d_tex[n][8*c +: 8] * d_wgt_r[n]);
        end
      end
    end
  end

  // output: sum, round half up, apply format
  logic [PROD_W+1:0] sum [4];
  byte_t             res [4];
  logic              out_vld_r;
  byte_t             out_a_r, out_r_r, out_g_r, out_b_r;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum[c] = (PROD_W+2)'(e_prod_r[c][0]) + (PROD_W+2)'(e_prod_r[c][1])
             + (PROD_W+2)'(e_prod_r[c][2]) + (PROD_W+2)'(e_prod_r[c][3])
             + (PROD_W+2)'(32768);
      res[c] = sum[c][23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (format_r == FMT_RGB || format_r == FMT_RGBA) begin
        out_a_r <= (format_r == FMT_RGBA) ? res[3] : 8'hFF;
        out_r_r <= res[0];
        out_g_r <= res[1];
        out_b_r <= res[2];
      end else begin
        out_a_r <= 8'hFF;
        out_r_r <= 8'h00;
        out_g_r <= 8'h00;
        out_b_r <= 8'h00;
      end
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.out_alpha = out_a_r;
  assign out_ch.out_red   = out_r_r;
  assign out_ch.out_green = out_g_r;
  assign out_ch.out_blue  = out_b_r;
endmodule

// ----- rtl/core/bts_checker.sv -----
// Port-level checker for the bilinear texture sampler, with its bind.
`include "bilinear_texture_sampler_unit_macros.svh"

module bts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word
);
  // a held result keeps its word
  `BTS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))
  // empty output register never blocks the input
  `BTS_ASSERT_IMP(a_rdy_empty, !out_valid, in_ready)
  // input stalls only behind an untaken result
  `BTS_ASSERT_IMP(a_rdy_stall, !in_ready, out_valid && !out_ready)
  // reset empties the pipeline
  `BTS_ASSERT_NXT_ANY(a_rst_empty, !rst_n, !out_valid)
endmodule

bind bilinear_texture_sampler_unit bts_checker u_bts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  ({out_ch.out_alpha, out_ch.out_red, out_ch.out_green, out_ch.out_blue})
);
